### rtl/irle_pkg.sv
// Shared types, codes and pixel unpacking for the run-length pixel decoder.
// Used by every module of the decoder; depends on nothing.
package irle_pkg;

  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 32;
  localparam int FmtW = 3;
  localparam int CountW = 32;
  localparam int PplW = 8;
  localparam int CopyW = 7;

  localparam logic [CfgIdxW-1:0] CFG_PIXEL_FORMAT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_TOTAL_PIXELS = 1'b1;

  localparam logic [FmtW-1:0] FMT_BGR24    = 3'd0;
  localparam logic [FmtW-1:0] FMT_BGRA32   = 3'd1;
  localparam logic [FmtW-1:0] FMT_RGB555   = 3'd2;
  localparam logic [FmtW-1:0] FMT_ARGB1555 = 3'd3;
  localparam logic [FmtW-1:0] FMT_GRAY8    = 3'd4;
  localparam logic [FmtW-1:0] FMT_GRAYA    = 3'd5;

  localparam logic [CountW-1:0] TOTAL_RESET = 32'd1;
  // Copies of a run sent for the byte that completes its pixel; the rest wait.
  localparam logic [CopyW-1:0] STEP_COPIES = 7'd64;
  localparam int HdrRunBit = 7;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic clear;       // start of image: drop all decoding state
    logic process;     // decode one byte
    logic use_stored;  // decode the stored byte instead of the port byte
    logic latch;       // store the port byte for later
    logic emit_run;    // send one copy of the current run
    logic emit_held;   // send one held copy of the previous run
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic run_start;
    logic run_pending;
    logic run_last;
    logic held_pending;
    logic held_last;
  } sts_t;

  function automatic logic [2:0] bytes_per_pixel(input logic [FmtW-1:0] fmt);
    logic [2:0] n;
    unique case (fmt)
      FMT_BGR24: n = 3'd3;
      FMT_BGRA32: n = 3'd4;
      FMT_RGB555, FMT_ARGB1555, FMT_GRAYA: n = 3'd2;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic rgba_t unpack_pixel(input logic [FmtW-1:0] fmt,
                                         input logic [31:0] w);
    rgba_t p;
    unique case (fmt)
      FMT_BGR24, FMT_BGRA32: begin
        p.blue  = w[7:0];
        p.green = w[15:8];
        p.red   = w[23:16];
        p.alpha = (fmt == FMT_BGRA32) ? w[31:24] : 8'hff;
      end
      FMT_RGB555, FMT_ARGB1555: begin
        p.red   = {w[14:10], 3'b000};
        p.green = {w[9:5], 3'b000};
        p.blue  = {w[4:0], 3'b000};
        p.alpha = (fmt == FMT_RGB555 || w[15]) ? 8'hff : 8'h00;
      end
      FMT_GRAYA: begin
        p.red   = w[7:0];
        p.green = w[7:0];
        p.blue  = w[7:0];
        p.alpha = w[15:8];
      end
      default: begin
        p.red   = w[7:0];
        p.green = w[7:0];
        p.blue  = w[7:0];
        p.alpha = 8'hff;
      end
    endcase
    return p;
  endfunction

endpackage

### rtl/irle_in_if.sv
// Input channel of the decoder: compressed bytes with a start-of-image flag.
// Valid/ready handshake; no dependencies.
interface irle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_image;

  modport source(output valid, output data_byte, output start_of_image, input ready);
  modport sink(input valid, input data_byte, input start_of_image, output ready);
endinterface

### rtl/irle_out_if.sv
// Result channel of the decoder: one RGBA pixel per beat with run and image marks.
// Valid/ready handshake; no dependencies.
interface irle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last_of_run;
  logic       last_of_image;

  modport source(output valid, output red, output green, output blue, output alpha,
                 output last_of_run, output last_of_image, input ready);
  modport sink(input valid, input red, input green, input blue, input alpha,
               input last_of_run, input last_of_image, output ready);
endinterface

### rtl/image_rle_pixel_decoder.sv
// Run-length pixel decoder: one compressed byte per beat in, one RGBA pixel per beat out.
// A byte that completes a raw pixel shows its pixel in the cycle after acceptance; a run's
// copies are counted, then sent one per cycle while the output register is free.
// Bytes are taken one per cycle while the output register drains; a run holds input for
// its copies (one a cycle while the output is free); held copies go before the next byte.
// Synchronous active-low reset: format bgr24, one pixel per image, decoding state cleared.
module image_rle_pixel_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [irle_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [irle_pkg::CfgDataW-1:0] cfg_wdata,
  irle_in_if.sink                       in_bus,
  irle_out_if.source                    out_bus
);

  irle_pkg::cmd_t  cmd;
  irle_pkg::sts_t  sts;
  irle_pkg::rgba_t pixel;

  irle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_sof   (in_bus.start_of_image),
    .in_ready (in_bus.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  irle_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_data_byte      (in_bus.data_byte),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_bus.ready),
    .out_valid         (out_bus.valid),
    .out_pixel         (pixel),
    .out_last_of_run   (out_bus.last_of_run),
    .out_last_of_image (out_bus.last_of_image)
  );

  assign out_bus.red   = pixel.red;
  assign out_bus.green = pixel.green;
  assign out_bus.blue  = pixel.blue;
  assign out_bus.alpha = pixel.alpha;

  // At most one thing happens to the decoder per cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.process, cmd.latch, cmd.emit_run, cmd.emit_held}))
    else $error("more than one decoder command in a cycle");

  // Copies are only sent into a free output register.
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_run || cmd.emit_held) |-> sts.slot_free)
    else $error("copy sent while output register is full");

  // A byte is parked only when held copies must go out first.
  a_latch_held: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |-> (sts.held_pending && !in_bus.start_of_image))
    else $error("byte parked without held copies");

  // No new byte is taken while a run still has copies to send.
  a_ready_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.ready |-> !sts.run_pending)
    else $error("input ready during a run");

endmodule

### rtl/irle_ctrl.sv
// Sequencer of the decoder: accepts bytes and steps through run and held copies.
// Depends on irle_pkg for the command and status structs.
module irle_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_sof,
  output logic             in_ready,
  input  irle_pkg::sts_t   sts,
  output irle_pkg::cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HELD = 2'd2;
  localparam logic [1:0] ST_PROC = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE) && sts.slot_free;
  assign accept = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // Held copies of the previous run go out before this byte is decoded,
          // unless a new image throws them away.
          if (!in_sof && sts.held_pending) begin
            cmd.latch = 1'b1;
            state_nxt = ST_HELD;
          end else begin
            cmd.clear = in_sof;
            cmd.process = 1'b1;
            if (sts.run_start) begin
              state_nxt = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        if (sts.slot_free) begin
          cmd.emit_run = 1'b1;
          if (sts.run_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_HELD: begin
        if (sts.slot_free) begin
          cmd.emit_held = 1'b1;
          if (sts.held_last) begin
            state_nxt = ST_PROC;
          end
        end
      end
      ST_PROC: begin
        if (sts.slot_free) begin
          cmd.process = 1'b1;
          cmd.use_stored = 1'b1;
          state_nxt = sts.run_start ? ST_RUN : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/irle_dp.sv
// Datapath of the decoder: configuration, packet and pixel state, run counters
// and the output register. Depends on irle_pkg.
module irle_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [irle_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [irle_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic [7:0]                    in_data_byte,
  input  irle_pkg::cmd_t                cmd,
  output irle_pkg::sts_t                sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output irle_pkg::rgba_t               out_pixel,
  output logic                          out_last_of_run,
  output logic                          out_last_of_image
);

  logic [irle_pkg::FmtW-1:0]   fmt_r;
  logic [irle_pkg::CountW-1:0] total_r;

  logic                        in_body_r, in_body_cur, in_body_nxt;
  logic                        is_run_r, is_run_cur, is_run_nxt;
  logic [irle_pkg::PplW-1:0]   ppl_r, ppl_cur, ppl_nxt;
  logic [1:0]                  bip_r, bip_cur, bip_nxt;
  logic [31:0]                 pb_r, pb_cur, pb_nxt;
  logic [irle_pkg::CountW-1:0] pd_r, pd_cur, pd_nxt;
  logic                        done_r, done_cur, done_nxt;
  logic [irle_pkg::CopyW-1:0]  held_r, held_nxt;
  logic [irle_pkg::CopyW-1:0]  run_left_r, run_left_nxt;
  irle_pkg::rgba_t             run_pix_r, run_pix_nxt;
  logic [7:0]                  byte_r;

  logic                        out_valid_r, out_valid_nxt;
  irle_pkg::rgba_t             out_pix_r, out_pix_nxt;
  logic                        out_lor_r, out_lor_nxt;
  logic                        out_loi_r, out_loi_nxt;

  logic [7:0]                  b;
  logic                        active;
  logic                        body;
  logic [31:0]                 pb_ins;
  logic [1:0]                  bip_inc;
  logic                        pix_done;
  irle_pkg::rgba_t             px;
  logic [irle_pkg::CountW-1:0] room;
  logic [irle_pkg::PplW-1:0]   m;
  logic [irle_pkg::CopyW-1:0]  now_cnt;
  logic                        emit_raw;
  logic                        run_start;
  logic                        load;
  logic [irle_pkg::CountW-1:0] pd_inc;

  assign sts.slot_free    = !out_valid_r || out_ready;
  assign sts.run_start    = run_start;
  assign sts.run_pending  = (run_left_r != '0);
  assign sts.run_last     = (run_left_r == irle_pkg::CopyW'(1));
  assign sts.held_pending = (held_r != '0);
  assign sts.held_last    = (held_r == irle_pkg::CopyW'(1));

  assign out_valid         = out_valid_r;
  assign out_pixel         = out_pix_r;
  assign out_last_of_run   = out_lor_r;
  assign out_last_of_image = out_loi_r;

  // Start of image acts on the state before this byte is decoded.
  assign in_body_cur = cmd.clear ? 1'b0 : in_body_r;
  assign is_run_cur  = cmd.clear ? 1'b0 : is_run_r;
  assign ppl_cur     = cmd.clear ? '0 : ppl_r;
  assign bip_cur     = cmd.clear ? '0 : bip_r;
  assign pb_cur      = cmd.clear ? '0 : pb_r;
  assign pd_cur      = cmd.clear ? '0 : pd_r;
  assign done_cur    = cmd.clear ? 1'b0 : done_r;

  assign b        = cmd.use_stored ? byte_r : in_data_byte;
  assign active   = cmd.process && !done_cur && (pd_cur < total_r);
  assign body     = active && in_body_cur;
  assign pb_ins   = pb_cur | ({24'h0, b} << {bip_cur, 3'b000});
  assign bip_inc  = bip_cur + 2'd1;
  assign pix_done = body &&
                    ((bip_inc == 2'd0) || ({1'b0, bip_inc} >= irle_pkg::bytes_per_pixel(fmt_r)));
  assign px       = irle_pkg::unpack_pixel(fmt_r, pb_ins);
  assign emit_raw  = pix_done && !is_run_cur;
  assign run_start = pix_done && is_run_cur;

  // Copies of a run are limited by the pixels left in the image.
  assign room    = total_r - pd_cur;
  assign m       = (room < irle_pkg::CountW'(ppl_cur)) ? room[irle_pkg::PplW-1:0] : ppl_cur;
  assign now_cnt = (m > irle_pkg::PplW'(irle_pkg::STEP_COPIES)) ?
                   irle_pkg::STEP_COPIES : m[irle_pkg::CopyW-1:0];

  assign load   = emit_raw || cmd.emit_run || cmd.emit_held;
  assign pd_inc = (emit_raw ? pd_cur : pd_r) + irle_pkg::CountW'(1);

  always_comb begin
    in_body_nxt  = in_body_cur;
    is_run_nxt   = is_run_cur;
    ppl_nxt      = ppl_cur;
    bip_nxt      = bip_cur;
    pb_nxt       = pb_cur;
    pd_nxt       = pd_cur;
    done_nxt     = done_cur;
    held_nxt     = cmd.clear ? '0 : held_r;
    run_left_nxt = run_left_r;
    run_pix_nxt  = run_pix_r;

    if (active && !in_body_cur) begin
      is_run_nxt  = b[irle_pkg::HdrRunBit];
      ppl_nxt     = {1'b0, b[6:0]} + irle_pkg::PplW'(1);
      in_body_nxt = 1'b1;
      bip_nxt     = '0;
      pb_nxt      = '0;
    end else if (body) begin
      if (pix_done) begin
        bip_nxt = '0;
        pb_nxt  = '0;
        if (is_run_cur) begin
          run_pix_nxt  = px;
          run_left_nxt = now_cnt;
          held_nxt     = m[irle_pkg::CopyW-1:0] - now_cnt;
          ppl_nxt      = '0;
          in_body_nxt  = 1'b0;
        end else begin
          ppl_nxt = ppl_cur - irle_pkg::PplW'(1);
          if (ppl_cur == irle_pkg::PplW'(1)) begin
            in_body_nxt = 1'b0;
          end
        end
      end else begin
        bip_nxt = bip_inc;
        pb_nxt  = pb_ins;
      end
    end

    if (cmd.emit_run) begin
      run_left_nxt = run_left_r - irle_pkg::CopyW'(1);
    end
    if (cmd.emit_held) begin
      held_nxt = held_r - irle_pkg::CopyW'(1);
    end
    if (load) begin
      pd_nxt = pd_inc;
      if (pd_inc >= total_r) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_pix_nxt   = out_pix_r;
    out_lor_nxt   = out_lor_r;
    out_loi_nxt   = out_loi_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_pix_nxt   = emit_raw ? px : run_pix_r;
      out_loi_nxt   = (pd_inc >= total_r);
      priority if (emit_raw) begin
        out_lor_nxt = 1'b1;
      end else if (cmd.emit_run) begin
        out_lor_nxt = (run_left_r == irle_pkg::CopyW'(1)) && (held_r == '0);
      end else begin
        out_lor_nxt = (held_r == irle_pkg::CopyW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= irle_pkg::FMT_BGR24;
      total_r     <= irle_pkg::TOTAL_RESET;
      in_body_r   <= 1'b0;
      is_run_r    <= 1'b0;
      ppl_r       <= '0;
      bip_r       <= '0;
      pb_r        <= '0;
      pd_r        <= '0;
      done_r      <= 1'b0;
      held_r      <= '0;
      run_left_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          irle_pkg::CFG_PIXEL_FORMAT: fmt_r <= cfg_wdata[irle_pkg::FmtW-1:0];
          irle_pkg::CFG_TOTAL_PIXELS: total_r <= cfg_wdata[irle_pkg::CountW-1:0];
          default: ;
        endcase
      end
      in_body_r   <= in_body_nxt;
      is_run_r    <= is_run_nxt;
      ppl_r       <= ppl_nxt;
      bip_r       <= bip_nxt;
      pb_r        <= pb_nxt;
      pd_r        <= pd_nxt;
      done_r      <= done_nxt;
      held_r      <= held_nxt;
      run_left_r  <= run_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_pix_r <= run_pix_nxt;
    out_pix_r <= out_pix_nxt;
    out_lor_r <= out_lor_nxt;
    out_loi_r <= out_loi_nxt;
    if (cmd.latch) begin
      byte_r <= in_data_byte;
    end
  end

endmodule
